[rtl/fralu_pkg.sv]
// Shared types, constants and the saturating helper function of the fraction ALU.
`timescale 1ns / 1ps
package fralu_pkg;

    localparam int WIDE_W = 64;
    localparam int RES_W  = 32;

    typedef logic signed [WIDE_W-1:0] wide_t;
    typedef logic signed [RES_W-1:0]  res_t;

    localparam logic [1:0] OP_ADD = 2'd0;
    localparam logic [1:0] OP_SUB = 2'd1;
    localparam logic [1:0] OP_MUL = 2'd2;
    localparam logic [1:0] OP_DIV = 2'd3;

    function automatic res_t sat32(input wide_t v);
        wide_t hi;
        wide_t lo;
        res_t  r;
        hi = WIDE_W'(signed'({1'b0, {(RES_W-1){1'b1}}}));
        lo = -hi - WIDE_W'(1);
        if (v > hi)
        begin
            r = {1'b0, {(RES_W-1){1'b1}}};
        end
        else if (v < lo)
        begin
            r = {1'b1, {(RES_W-1){1'b0}}};
        end
        else
        begin
            r = v[RES_W-1:0];
        end
        return r;
    endfunction

endpackage

[rtl/fralu_mul.sv]
// Registered signed multiplier shared by all cross products.
`timescale 1ns / 1ps
module fralu_mul #(
    parameter int OPERAND_WIDTH = 16
) (
    input  logic                            clk,
    input  logic signed [OPERAND_WIDTH-1:0] x,
    input  logic signed [OPERAND_WIDTH-1:0] y,
    output fralu_pkg::wide_t                prod
);
    import fralu_pkg::*;

    logic signed [2*OPERAND_WIDTH-1:0] full;
    wide_t prod_reg;
    wide_t prod_next;

    assign full      = x * y;
    assign prod_next = WIDE_W'(full);

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    assign prod = prod_reg;
endmodule

[rtl/fralu_div.sv]
// Bit-serial truncating signed divider giving quotient and remainder.
`timescale 1ns / 1ps
module fralu_div (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  fralu_pkg::wide_t dividend,
    input  fralu_pkg::wide_t divisor,
    output logic             done,
    output fralu_pkg::wide_t quot,
    output fralu_pkg::wide_t rem
);
    import fralu_pkg::*;

    logic [WIDE_W-1:0] n_reg, n_next;
    logic [WIDE_W-1:0] d_reg, d_next;
    logic [WIDE_W-1:0] r_reg, r_next;
    logic [6:0]        cnt_reg, cnt_next;
    logic              done_reg, done_next;
    logic              negq_reg, negq_next;
    logic              negr_reg, negr_next;
    logic [WIDE_W:0]   shifted;
    logic [WIDE_W:0]   trial;

    assign shifted = {r_reg, n_reg[WIDE_W-1]};
    assign trial   = shifted - {1'b0, d_reg};

    always_comb
    begin
        n_next    = n_reg;
        d_next    = d_reg;
        r_next    = r_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        negq_next = negq_reg;
        negr_next = negr_reg;
        if (start)
        begin
            n_next    = dividend[WIDE_W-1] ? -dividend : dividend;
            d_next    = divisor[WIDE_W-1] ? -divisor : divisor;
            r_next    = '0;
            cnt_next  = 7'(WIDE_W);
            negq_next = dividend[WIDE_W-1] ^ divisor[WIDE_W-1];
            negr_next = dividend[WIDE_W-1];
        end
        else if (cnt_reg != '0)
        begin
            if (trial[WIDE_W])
            begin
                r_next = shifted[WIDE_W-1:0];
                n_next = {n_reg[WIDE_W-2:0], 1'b0};
            end
            else
            begin
                r_next = trial[WIDE_W-1:0];
                n_next = {n_reg[WIDE_W-2:0], 1'b1};
            end
            cnt_next = cnt_reg - 7'd1;
            if (cnt_reg == 7'd1)
            begin
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg    <= n_next;
        d_reg    <= d_next;
        r_reg    <= r_next;
        negq_reg <= negq_next;
        negr_reg <= negr_next;
    end

    assign done = done_reg;
    assign quot = negq_reg ? -wide_t'(n_reg) : wide_t'(n_reg);
    assign rem  = negr_reg ? -wide_t'(r_reg) : wide_t'(r_reg);
endmodule

[rtl/fraction_alu_with_reduction.sv]
// Top level of the fraction ALU: operand capture, sequencer and result register.
`timescale 1ns / 1ps
// The block takes one transaction on the input channel (in_valid, in_stall): an opcode
// and two signed fractions. It adds, subtracts, multiplies or divides them by cross
// multiplication and reduces the result by Euclid's algorithm with truncating remainders.
// A zero input denominator is taken as one. A zero result denominator sets status and
// clears both result fields.
// One shared multiplier forms the cross products one after another. One bit-serial
// divider of 64 steps serves every Euclid step and the two final divisions by the
// divisor found; a zero result denominator skips the divider. in_stall is high from
// acceptance until the result is written to the output register.
// The result leaves on the output channel (out_valid, out_stall) from a register; a new
// item may be accepted while the previous result still waits there. When the receiver
// stalls, the result holds and a finished second result waits inside until taken.
// Reset clears the sequencer and the output valid flag.
module fraction_alu_with_reduction #(
    parameter int OPERAND_WIDTH = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [1:0]                      opcode,
    input  logic signed [OPERAND_WIDTH-1:0] a_num,
    input  logic signed [OPERAND_WIDTH-1:0] a_den,
    input  logic signed [OPERAND_WIDTH-1:0] b_num,
    input  logic signed [OPERAND_WIDTH-1:0] b_den,
    output logic                            out_valid,
    input  logic                            out_stall,
    output fralu_pkg::res_t                 res_num,
    output fralu_pkg::res_t                 res_den,
    output logic                            status
);
    import fralu_pkg::*;

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_M1   = 4'd1;
    localparam logic [3:0] ST_M2   = 4'd2;
    localparam logic [3:0] ST_M3   = 4'd3;
    localparam logic [3:0] ST_M4   = 4'd4;
    localparam logic [3:0] ST_GCD  = 4'd5;
    localparam logic [3:0] ST_GW   = 4'd6;
    localparam logic [3:0] ST_QS   = 4'd7;
    localparam logic [3:0] ST_QW   = 4'd8;
    localparam logic [3:0] ST_DS   = 4'd9;
    localparam logic [3:0] ST_DW   = 4'd10;
    localparam logic [3:0] ST_DONE = 4'd11;

    localparam logic signed [OPERAND_WIDTH-1:0] ONE = OPERAND_WIDTH'(1);

    logic [3:0] st_reg, st_next;
    logic [1:0] op_reg, op_next;
    logic signed [OPERAND_WIDTH-1:0] an_reg, an_next, ad_reg, ad_next;
    logic signed [OPERAND_WIDTH-1:0] bn_reg, bn_next, bd_reg, bd_next;
    wide_t p1_reg, p1_next, p2_reg, p2_next;
    wide_t num_reg, num_next, den_reg, den_next;
    wide_t a_reg, a_next, b_reg, b_next, g_reg, g_next;
    res_t  rn_reg, rn_next, rd_reg, rd_next;
    logic  st_flag_reg, st_flag_next;
    logic  ov_reg, ov_next;
    res_t  on_reg, on_next, od_reg, od_next;
    logic  os_reg, os_next;

    logic signed [OPERAND_WIDTH-1:0] mx, my;
    wide_t prod;
    logic  div_start, div_done;
    wide_t div_a, div_b, quot, rem;
    wide_t cn, cd;
    logic  out_free;

    fralu_mul #(.OPERAND_WIDTH(OPERAND_WIDTH)) u_mul (
        .clk  (clk),
        .x    (mx),
        .y    (my),
        .prod (prod)
    );

    fralu_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_a),
        .divisor  (div_b),
        .done     (div_done),
        .quot     (quot),
        .rem      (rem)
    );

    assign in_stall = (st_reg != ST_IDLE);
    assign out_free = !ov_reg || !out_stall;

    always_comb
    begin
        mx = an_reg;
        my = bd_reg;
        unique case (st_reg)
            ST_M1:
            begin
                mx = an_reg;
                my = (op_reg == OP_MUL) ? bn_reg : bd_reg;
            end
            ST_M2:
            begin
                mx = ad_reg;
                my = bn_reg;
            end
            ST_M3:
            begin
                mx = ad_reg;
                my = bd_reg;
            end
            default:
            begin
                mx = an_reg;
                my = bd_reg;
            end
        endcase
    end

    always_comb
    begin
        unique case (op_reg)
            OP_ADD:
            begin
                cn = p1_reg + p2_reg;
                cd = prod;
            end
            OP_SUB:
            begin
                cn = p1_reg - p2_reg;
                cd = prod;
            end
            OP_MUL:
            begin
                cn = p1_reg;
                cd = prod;
            end
            default:
            begin
                cn = p1_reg;
                cd = p2_reg;
            end
        endcase
    end

    always_comb
    begin
        div_start = 1'b0;
        div_a     = a_reg;
        div_b     = b_reg;
        unique case (st_reg)
            ST_GCD:
            begin
                div_start = (b_reg != '0);
            end
            ST_QS:
            begin
                div_start = 1'b1;
                div_a     = num_reg;
                div_b     = g_reg;
            end
            ST_DS:
            begin
                div_start = 1'b1;
                div_a     = den_reg;
                div_b     = g_reg;
            end
            default:
            begin
                div_start = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        st_next      = st_reg;
        op_next      = op_reg;
        an_next      = an_reg;
        ad_next      = ad_reg;
        bn_next      = bn_reg;
        bd_next      = bd_reg;
        p1_next      = p1_reg;
        p2_next      = p2_reg;
        num_next     = num_reg;
        den_next     = den_reg;
        a_next       = a_reg;
        b_next       = b_reg;
        g_next       = g_reg;
        rn_next      = rn_reg;
        rd_next      = rd_reg;
        st_flag_next = st_flag_reg;
        ov_next      = ov_reg;
        on_next      = on_reg;
        od_next      = od_reg;
        os_next      = os_reg;

        if (ov_reg && !out_stall)
        begin
            ov_next = 1'b0;
        end

        unique case (st_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    op_next = opcode;
                    an_next = a_num;
                    ad_next = (a_den == '0) ? ONE : a_den;
                    bn_next = b_num;
                    bd_next = (b_den == '0) ? ONE : b_den;
                    st_next = ST_M1;
                end
            end
            ST_M1:
            begin
                st_next = ST_M2;
            end
            ST_M2:
            begin
                p1_next = prod;
                st_next = ST_M3;
            end
            ST_M3:
            begin
                p2_next = prod;
                st_next = ST_M4;
            end
            ST_M4:
            begin
                num_next = cn;
                den_next = cd;
                a_next   = cn;
                b_next   = cd;
                if (cd == '0)
                begin
                    rn_next      = '0;
                    rd_next      = '0;
                    st_flag_next = 1'b1;
                    st_next      = ST_DONE;
                end
                else
                begin
                    st_flag_next = 1'b0;
                    st_next      = ST_GCD;
                end
            end
            ST_GCD:
            begin
                if (b_reg == '0)
                begin
                    g_next  = a_reg;
                    st_next = ST_QS;
                end
                else
                begin
                    st_next = ST_GW;
                end
            end
            ST_GW:
            begin
                if (div_done)
                begin
                    a_next  = b_reg;
                    b_next  = rem;
                    st_next = ST_GCD;
                end
            end
            ST_QS:
            begin
                st_next = ST_QW;
            end
            ST_QW:
            begin
                if (div_done)
                begin
                    rn_next = sat32(quot);
                    st_next = ST_DS;
                end
            end
            ST_DS:
            begin
                st_next = ST_DW;
            end
            ST_DW:
            begin
                if (div_done)
                begin
                    rd_next = sat32(quot);
                    st_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    ov_next = 1'b1;
                    on_next = rn_reg;
                    od_next = rd_reg;
                    os_next = st_flag_reg;
                    st_next = ST_IDLE;
                end
            end
            default:
            begin
                st_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= ST_IDLE;
            ov_reg <= 1'b0;
        end
        else
        begin
            st_reg <= st_next;
            ov_reg <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        an_reg      <= an_next;
        ad_reg      <= ad_next;
        bn_reg      <= bn_next;
        bd_reg      <= bd_next;
        p1_reg      <= p1_next;
        p2_reg      <= p2_next;
        num_reg     <= num_next;
        den_reg     <= den_next;
        a_reg       <= a_next;
        b_reg       <= b_next;
        g_reg       <= g_next;
        rn_reg      <= rn_next;
        rd_reg      <= rd_next;
        st_flag_reg <= st_flag_next;
        on_reg      <= on_next;
        od_reg      <= od_next;
        os_reg      <= os_next;
    end

    assign out_valid = ov_reg;
    assign res_num   = on_reg;
    assign res_den   = od_reg;
    assign status    = os_reg;
endmodule

[bench/fraction_alu_with_reduction_checker.sv]
// Checker that predicts and compares every result of the fraction ALU.
`timescale 1ns / 1ps
module fraction_alu_with_reduction_checker (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    input  logic                   in_stall,
    input  logic [1:0]             opcode,
    input  logic signed [15:0]     a_num,
    input  logic signed [15:0]     a_den,
    input  logic signed [15:0]     b_num,
    input  logic signed [15:0]     b_den,
    input  logic                   out_valid,
    input  logic                   out_stall,
    input  fralu_pkg::res_t        res_num,
    input  fralu_pkg::res_t        res_den,
    input  logic                   status,
    output int                     errors,
    output int                     pending
);
    import fralu_pkg::*;

    typedef struct packed {
        res_t num;
        res_t den;
        logic flag;
    } fraction_t;

    fraction_t  expect_mem [0:15];
    logic [3:0] wr_idx = 4'd0;
    logic [3:0] rd_idx = 4'd0;
    int         held = 0;

    function automatic wide_t rem_trunc(wide_t a, wide_t b);
        if (b == 1 || b == -1)
        begin
            return '0;
        end
        return a % b;
    endfunction

    function automatic wide_t div_trunc(wide_t a, wide_t b);
        if (b == -1)
        begin
            return -a;
        end
        return a / b;
    endfunction

    function automatic res_t clamp32(wide_t v);
        if (v > 64'sd2147483647)
        begin
            return 32'sh7fffffff;
        end
        if (v < -64'sd2147483648)
        begin
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

    function automatic fraction_t reduce_fraction(logic [1:0] op, logic signed [15:0] an,
                                                  logic signed [15:0] ad,
                                                  logic signed [15:0] bn,
                                                  logic signed [15:0] bd);
        wide_t wan;
        wide_t wad;
        wide_t wbn;
        wide_t wbd;
        wide_t num;
        wide_t den;
        wide_t x;
        wide_t y;
        wide_t r;
        fraction_t f;
        wan = wide_t'(an);
        wad = (ad == 0) ? 64'sd1 : wide_t'(ad);
        wbn = wide_t'(bn);
        wbd = (bd == 0) ? 64'sd1 : wide_t'(bd);
        case (op)
            OP_ADD:
            begin
                num = wan * wbd + wad * wbn;
                den = wad * wbd;
            end
            OP_SUB:
            begin
                num = wan * wbd - wad * wbn;
                den = wad * wbd;
            end
            OP_MUL:
            begin
                num = wan * wbn;
                den = wad * wbd;
            end
            default:
            begin
                num = wan * wbd;
                den = wad * wbn;
            end
        endcase
        if (den == 0)
        begin
            f.num = '0;
            f.den = '0;
            f.flag = 1'b1;
            return f;
        end
        x = num;
        y = den;
        while (y != 0)
        begin
            r = rem_trunc(x, y);
            x = y;
            y = r;
        end
        f.num = clamp32(div_trunc(num, x));
        f.den = clamp32(div_trunc(den, x));
        f.flag = 1'b0;
        return f;
    endfunction

    assign pending = held;

    initial errors = 0;

    always @(posedge clk)
    begin
        fraction_t want;
        if (rst_n && in_valid && !in_stall)
        begin
            expect_mem[wr_idx] = reduce_fraction(opcode, a_num, a_den, b_num, b_den);
            wr_idx = wr_idx + 4'd1;
            held = held + 1;
        end
        if (rst_n && out_valid && !out_stall)
        begin
            if (held == 0)
            begin
                errors <= errors + 1;
                if (errors < 10)
                begin
                    $display("unexpected result %0d/%0d status %0b", res_num, res_den, status);
                end
            end
            else
            begin
                want = expect_mem[rd_idx];
                rd_idx = rd_idx + 4'd1;
                held = held - 1;
                if (want.num !== res_num || want.den !== res_den || want.flag !== status)
                begin
                    errors <= errors + 1;
                    if (errors < 10)
                    begin
                        $display("mismatch: expected %0d/%0d status %0b, got %0d/%0d status %0b",
                                 want.num, want.den, want.flag, res_num, res_den, status);
                    end
                end
            end
        end
    end
endmodule

[bench/fraction_alu_with_reduction_test.sv]
// Top of the fraction ALU testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module fraction_alu_with_reduction_test;
    import fralu_pkg::*;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [1:0] opcode = OP_ADD;
    logic signed [15:0] a_num = 0;
    logic signed [15:0] a_den = 0;
    logic signed [15:0] b_num = 0;
    logic signed [15:0] b_den = 0;
    logic out_valid;
    logic out_stall = 1'b0;
    res_t res_num;
    res_t res_den;
    logic status;
    int errors;
    int pending;
    logic hold_request = 1'b0;
    longint cycles = 0;

    localparam longint CYCLE_LIMIT = 40000000;

    always #1 clk = ~clk;

    fraction_alu_with_reduction #(.OPERAND_WIDTH(16)) dut (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .opcode(opcode), .a_num(a_num), .a_den(a_den), .b_num(b_num), .b_den(b_den),
        .out_valid(out_valid), .out_stall(out_stall),
        .res_num(res_num), .res_den(res_den), .status(status)
    );

    fraction_alu_with_reduction_checker u_checker (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .opcode(opcode), .a_num(a_num), .a_den(a_den), .b_num(b_num), .b_den(b_den),
        .out_valid(out_valid), .out_stall(out_stall),
        .res_num(res_num), .res_den(res_den), .status(status),
        .errors(errors), .pending(pending)
    );

    function automatic int gap_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
        begin
            return 0;
        end
        if (r < 90)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 60);
    endfunction

    function automatic logic signed [15:0] pick_operand();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65)
        begin
            return 16'($urandom_range(0, 100) - 50);
        end
        if (r < 85)
        begin
            return 16'($urandom());
        end
        case ($urandom_range(0, 5))
            0: return 16'sd32767;
            1: return -16'sd32767;
            2: return 16'sh8000;
            3: return 16'sd0;
            4: return 16'sd1;
            default: return -16'sd1;
        endcase
    endfunction

    task automatic send_fraction(logic [1:0] op, logic signed [15:0] an,
                                 logic signed [15:0] ad, logic signed [15:0] bn,
                                 logic signed [15:0] bd);
        int g;
        in_valid <= 1'b1;
        opcode <= op;
        a_num <= an;
        a_den <= ad;
        b_num <= bn;
        b_den <= bd;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        g = gap_length();
        if (g > 0)
        begin
            in_valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
    endtask

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("fraction_alu_with_reduction test failed");
            $finish;
        end
    end

    initial
    begin
        int hold;
        int g;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                out_stall <= 1'b1;
                for (hold = 0; hold < 30000; hold++)
                begin
                    @(posedge clk);
                end
                out_stall <= 1'b0;
                wait (!hold_request);
            end
            else if ($urandom_range(0, 3) == 0)
            begin
                g = gap_length();
                out_stall <= (g > 0);
                repeat (g) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    initial
    begin
        int n;
        logic [1:0] op;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_fraction(OP_ADD, 16'sd1, 16'sd2, 16'sd1, 16'sd3);
        send_fraction(OP_SUB, 16'sd1, 16'sd2, 16'sd1, 16'sd2);
        send_fraction(OP_MUL, 16'sd2, 16'sd3, 16'sd3, 16'sd4);
        send_fraction(OP_DIV, 16'sd1, 16'sd2, 16'sd3, 16'sd4);
        send_fraction(OP_DIV, 16'sd5, 16'sd7, 16'sd0, 16'sd3);
        send_fraction(OP_ADD, 16'sd3, 16'sd0, 16'sd4, 16'sd0);
        send_fraction(OP_MUL, -16'sd6, 16'sd4, 16'sd2, -16'sd9);
        send_fraction(OP_ADD, 16'sd32767, 16'sd1, 16'sd32767, 16'sd1);
        send_fraction(OP_SUB, -16'sd32767, 16'sd32767, 16'sd32767, -16'sd32767);
        send_fraction(OP_MUL, 16'sh8000, 16'sd1, 16'sh8000, 16'sd1);
        send_fraction(OP_DIV, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
        send_fraction(OP_MUL, 16'sd32767, 16'sd1, 16'sd32767, 16'sd1);
        send_fraction(OP_DIV, 16'sd32767, 16'sd1, 16'sd1, 16'sd32767);
        send_fraction(OP_DIV, 16'sh8000, 16'sd1, 16'sd1, 16'sh8000);
        send_fraction(OP_ADD, 16'sd0, -16'sd5, 16'sd0, 16'sd7);
        send_fraction(OP_SUB, 16'sd32767, 16'sd32766, -16'sd32767, 16'sd32765);
        send_fraction(OP_DIV, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
        send_fraction(OP_MUL, -16'sd1, -16'sd1, -16'sd1, -16'sd1);

        for (n = 0; n < 1700; n++)
        begin
            if (n == 400)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
                wait (pending == 0);
                @(posedge clk);
            end
            if (n == 900)
            begin
                hold_request <= 1'b1;
            end
            if (n == 920)
            begin
                hold_request <= 1'b0;
            end
            op = 2'($urandom_range(0, 3));
            send_fraction(op, pick_operand(), pick_operand(), pick_operand(), pick_operand());
        end
        in_valid <= 1'b0;
        wait (pending == 0);
        repeat (200) @(posedge clk);
        if (errors == 0 && pending == 0)
        begin
            $display("fraction_alu_with_reduction test passed");
        end
        else
        begin
            $display("fraction_alu_with_reduction test failed");
        end
        $finish;
    end
endmodule
